/* src/msw_pkg.sv */
// Shared definitions for the menu scroll window controller.
// Holds command and register codes, field widths and the result word type.
// No dependencies.
package msw_pkg;

  localparam int CMD_W    = 3;
  localparam int IDX_W    = 8;
  localparam int CFG_W    = 9;
  localparam int CFG_IX_W = 1;

  localparam logic [CMD_W-1:0] CMD_LINE_UP   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_LINE_DOWN = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PAGE_UP   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_PAGE_DOWN = 3'd3;
  localparam logic [CMD_W-1:0] CMD_FIRST     = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LAST      = 3'd5;
  localparam logic [CMD_W-1:0] CMD_JUMP      = 3'd6;

  localparam logic [CFG_IX_W-1:0] REG_ITEM_COUNT    = 1'b0;
  localparam logic [CFG_IX_W-1:0] REG_VISIBLE_SPACE = 1'b1;

  typedef struct packed {
    logic [IDX_W-1:0] selection;
    logic [IDX_W-1:0] previous_selection;
    logic [IDX_W-1:0] first_visible;
    logic [IDX_W-1:0] last_visible;
    logic             scrolling;
    logic             repaint_all;
    logic             repaint_selection;
  } msw_result_t;

endpackage

/* src/msw_if.sv */
// Handshake channels of the menu scroll window controller.
// Depends on msw_pkg for the field widths.
interface msw_request_if;
  import msw_pkg::*;
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [IDX_W-1:0] new_selection;
  modport source (output valid, command, new_selection, input ready);
  modport sink (input valid, command, new_selection, output ready);
endinterface

interface msw_report_if;
  import msw_pkg::*;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] selection;
  logic [IDX_W-1:0] previous_selection;
  logic [IDX_W-1:0] first_visible;
  logic [IDX_W-1:0] last_visible;
  logic             scrolling;
  logic             repaint_all;
  logic             repaint_selection;
  modport source (output valid, selection, previous_selection, first_visible, last_visible,
                  scrolling, repaint_all, repaint_selection, input ready);
  modport sink (input valid, selection, previous_selection, first_visible, last_visible,
                scrolling, repaint_all, repaint_selection, output ready);
endinterface

/* src/menu_scroll_window_controller_top.sv */
// Cursor and scroll window controller for a list menu. Takes one command word per cycle while
// request.ready is high and returns one registered report word per command; the cursor, window
// top and repaint state update as the command is accepted, so commands may follow back to back. A
// two-word output queue lets a new command in while one report still waits; request.ready
// drops only when both queue slots are occupied. Any register write restarts the cursor and
// window at the top with a full repaint pending. Depends on msw_pkg and the msw interfaces.
module menu_scroll_window_controller_top #(
  parameter int MAX_ITEMS = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [msw_pkg::CFG_IX_W-1:0]  cfg_index,
  input  logic [msw_pkg::CFG_W-1:0]     cfg_wdata,
  msw_request_if.sink                   request,
  msw_report_if.source                  report
);
  import msw_pkg::*;

  // index width follows the list depth; a 9-bit count never needs more than 9 bits
  localparam int IW = ($clog2(MAX_ITEMS) < CFG_W) ? $clog2(MAX_ITEMS) : CFG_W;
  localparam int AW = ((IW > IDX_W) ? IW : IDX_W) + 2;
  localparam int CAP_I = (MAX_ITEMS > (2**CFG_W) - 1) ? (2**CFG_W) - 1 : MAX_ITEMS;
  localparam logic [CFG_W:0] CAP = (CFG_W+1)'(CAP_I);

  // configuration and derived limits
  logic [CFG_W-1:0] item_count, visible_space;
  logic [IW-1:0]    last_index, page_size, top_limit;
  logic             scrolling;

  logic [CFG_W-1:0] count_sel, space_sel;
  logic [CFG_W:0]   n_ext, v_ext, n_sat, v_sat;
  logic [IW-1:0]    last_index_next, page_size_next, top_limit_next;
  logic             scrolling_next;
  logic             cfg_hit;

  always_comb begin
    count_sel = item_count;
    space_sel = visible_space;
    cfg_hit   = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_ITEM_COUNT: begin
          count_sel = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        REG_VISIBLE_SPACE: begin
          space_sel = cfg_wdata;
          cfg_hit   = 1'b1;
        end
        default: cfg_hit = 1'b0;
      endcase
    end
    n_ext = {1'b0, count_sel};
    v_ext = {1'b0, space_sel};
    n_sat = (n_ext == '0) ? (CFG_W+1)'(1) : ((n_ext > CAP) ? CAP : n_ext);
    v_sat = (v_ext > CAP) ? CAP : v_ext;
    last_index_next = IW'(n_sat - (CFG_W+1)'(1));
    page_size_next  = (v_sat == '0) ? last_index_next : IW'(v_sat - (CFG_W+1)'(1));
    scrolling_next  = last_index_next > page_size_next;
    top_limit_next  = scrolling_next ? (last_index_next - page_size_next) : '0;
  end

  // cursor state
  logic [IW-1:0] cursor, window_top;
  logic          full_pending;

  logic signed [AW-1:0] cur_s, top_s, l_s, p_s, lim_s, bot_s, tgt_s;
  logic signed [AW-1:0] nc, nt;
  logic                 nf, recentre;
  msw_result_t          result;

  function automatic logic signed [AW-1:0] clamp(input logic signed [AW-1:0] v,
                                                  input logic signed [AW-1:0] hi);
    logic signed [AW-1:0] r;
    r = v;
    if (v < 0) r = '0;
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_comb begin
    cur_s = AW'(cursor);
    top_s = AW'(window_top);
    l_s   = AW'(last_index);
    p_s   = AW'(page_size);
    lim_s = AW'(top_limit);
    bot_s = top_s + p_s;
    tgt_s = AW'(request.new_selection);
    nc = cur_s;
    nt = top_s;
    nf = full_pending;
    recentre = 1'b0;
    unique case (request.command)
      CMD_LINE_UP: begin
        if (cur_s > 0) begin
          nc = cur_s - AW'(1);
          recentre = nc < top_s;
        end
      end
      CMD_LINE_DOWN: begin
        if (cur_s < l_s) begin
          nc = cur_s + AW'(1);
          recentre = nc > bot_s;
        end
      end
      CMD_PAGE_UP: begin
        if (cur_s > 0) begin
          if (cur_s == l_s) begin
            nc = scrolling ? cur_s - (p_s - AW'(1)) : '0;
          end else begin
            nf = nf | (top_s > 0);
            nc = cur_s - p_s;
            nt = top_s - p_s;
          end
          nc = clamp(nc, l_s);
          nt = clamp(nt, lim_s);
        end
      end
      CMD_PAGE_DOWN: begin
        if (cur_s < l_s) begin
          if (cur_s == 0) begin
            nc = scrolling ? p_s - AW'(1) : l_s;
          end else begin
            nf = nf | (top_s < lim_s);
            nc = cur_s + p_s;
            nt = top_s + p_s;
          end
          nc = clamp(nc, l_s);
          nt = clamp(nt, lim_s);
        end
      end
      CMD_FIRST: begin
        if (cur_s > 0) begin
          nc = '0;
          if (top_s > 0) begin
            nf = 1'b1;
            nt = '0;
          end
        end
      end
      CMD_LAST: begin
        if (cur_s < l_s) begin
          nc = l_s;
          if (top_s < lim_s) begin
            nf = 1'b1;
            nt = lim_s;
          end
        end
      end
      CMD_JUMP: begin
        nc = (tgt_s > l_s) ? l_s : tgt_s;
        recentre = (nc < top_s) || (nc > bot_s);
      end
      default: nc = cur_s;
    endcase
    // pull the window so the cursor sits near its middle
    if (recentre) begin
      nf = 1'b1;
      nt = clamp(nc - (p_s >>> 1), lim_s);
    end
    result.selection          = IDX_W'(nc);
    result.previous_selection = IDX_W'(cur_s);
    result.first_visible      = IDX_W'(nt);
    result.last_visible       = IDX_W'(nt + p_s);
    result.scrolling          = scrolling;
    result.repaint_all        = nf;
    result.repaint_selection  = !nf && (nc != cur_s);
  end

  // output queue, two words deep
  msw_result_t q0, q1;
  logic [1:0]  count;
  logic        push, pop;

  assign request.ready = (count != 2'd2);
  assign push = request.valid && request.ready;
  assign pop  = report.valid && report.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_count    <= CFG_W'(1);
      visible_space <= '0;
      last_index    <= '0;
      page_size     <= '0;
      top_limit     <= '0;
      scrolling     <= 1'b0;
      cursor        <= '0;
      window_top    <= '0;
      full_pending  <= 1'b1;
    end else if (cfg_hit) begin
      item_count    <= count_sel;
      visible_space <= space_sel;
      last_index    <= last_index_next;
      page_size     <= page_size_next;
      top_limit     <= top_limit_next;
      scrolling     <= scrolling_next;
      cursor        <= '0;
      window_top    <= '0;
      full_pending  <= 1'b1;
    end else if (push) begin
      cursor       <= IW'(nc);
      window_top   <= IW'(nt);
      full_pending <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (count == 2'd2) q0 <= q1;
      else if (push) q0 <= result;
      if (count == 2'd2 && push) q1 <= result;
    end else if (push) begin
      if (count == 2'd0) q0 <= result;
      else q1 <= result;
    end
  end

  assign report.valid              = (count != 2'd0);
  assign report.selection          = q0.selection;
  assign report.previous_selection = q0.previous_selection;
  assign report.first_visible      = q0.first_visible;
  assign report.last_visible       = q0.last_visible;
  assign report.scrolling          = q0.scrolling;
  assign report.repaint_all        = q0.repaint_all;
  assign report.repaint_selection  = q0.repaint_selection;

endmodule

/* src/msw_checker.sv */
// Port-level checks for the menu scroll window controller.
// Bound to menu_scroll_window_controller_top; depends on msw_pkg for widths.
module msw_port_checks (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_ready,
  input logic                      rep_valid,
  input logic                      rep_ready,
  input logic [msw_pkg::IDX_W-1:0] rep_selection,
  input logic                      rep_repaint_all,
  input logic                      rep_repaint_selection
);
  import msw_pkg::*;

  // the two repaint kinds exclude each other
  a_repaint_excl: assert property (@(posedge clk) disable iff (rst)
    rep_valid |-> !(rep_repaint_all && rep_repaint_selection))
    else $error("repaint_all and repaint_selection both set");

  // back-pressure on commands only when reports are queued
  a_ready_backlog: assert property (@(posedge clk) disable iff (rst)
    !req_ready |-> rep_valid)
    else $error("request stalled with no report waiting");

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    rep_valid && !rep_ready |=> rep_valid)
    else $error("report dropped while stalled");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    rep_valid && !rep_ready |=> $stable(rep_selection))
    else $error("report word changed while stalled");

endmodule

bind menu_scroll_window_controller_top msw_port_checks u_msw_checker (
  .clk                   (clk),
  .rst                   (rst),
  .req_ready             (request.ready),
  .rep_valid             (report.valid),
  .rep_ready             (report.ready),
  .rep_selection         (report.selection),
  .rep_repaint_all       (report.repaint_all),
  .rep_repaint_selection (report.repaint_selection)
);
